>>> sv/ngpc_pkg.sv
// ============================================================================
// ngpc_pkg : shared types, constants and functions of the neural gain
// P controller (cell commands, saturation, input scaling, tanh table).
// ============================================================================
package ngpc_pkg;

    // Default sizes
    localparam int HIDDEN_COUNT_DEF = 8;
    localparam int TANH_DEPTH_DEF   = 256;
    localparam int TANH_MAX_DEPTH   = 4096;
    localparam int TANH_IDX_W       = 12;

    // Field widths
    localparam int KIND_W  = 2;
    localparam int DATA_W  = 24;
    localparam int WIDX_W  = 6;
    localparam int GAIN_W  = 18;
    localparam int LR_W    = 16;
    localparam int CFG_IDX_W = 1;

    // Internal widths
    localparam int NV_W    = 18;   // values in [-1,1] Q16
    localparam int OP_W    = 25;   // multiplier operands
    localparam int PROD_W  = 50;
    localparam int ACC_W   = 52;
    localparam int X_W     = 36;
    localparam int CHAIN_W = 42;
    localparam int OSUM_W  = 48;
    localparam int ERR_W   = 29;
    localparam int SAT_W   = 56;
    localparam int STEP_W  = 5;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LEARN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEARN_ERROR = 1'd1;

    localparam logic [LR_W-1:0]          LEARN_RATE_RST  = 16'd66;
    localparam logic signed [DATA_W-1:0] LEARN_ERROR_RST = 24'sd65536;

    // Numeric constants
    localparam logic signed [NV_W-1:0]  ONE_Q16  = 18'sd65536;
    localparam logic signed [SAT_W-1:0] S24_MAX  = 56'sd8388607;
    localparam logic signed [SAT_W-1:0] S24_MIN  = -56'sd8388608;
    localparam logic signed [SAT_W-1:0] CLIP_HI  = 56'sd65536;
    localparam logic signed [SAT_W-1:0] CLIP_LO  = -56'sd65536;
    localparam logic signed [DATA_W-1:0] GAIN_LO = 24'sd98304;
    localparam logic signed [DATA_W-1:0] GAIN_HI = 24'sd163840;
    localparam logic [23:0] ANG_LIMIT  = 24'd7680;    // 30 deg maps to 1.0
    localparam logic [23:0] RATE_LIMIT = 24'd51200;   // 200 deg/s maps to 1.0
    localparam logic [20:0] ANG_RECIP  = 21'd1118482; // ceil(2^24/15)
    localparam logic [21:0] RATE_RECIP = 22'd2684355; // ceil(2^26/25)

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_FWD,
        ST_REDUCE,
        ST_GAIN,
        ST_DMUL,
        ST_DRIVE,
        ST_LEARN
    } t_state;

    // Multiplier operand selection inside a cell
    typedef enum logic [3:0] {
        M_NONE, M_X0, M_X1, M_X2, M_HWO, M_GH, M_LRLO, M_LRHI,
        M_GWO, M_HH, M_PQ, M_LRD, M_DX0, M_DX1, M_DX2
    } t_mul_sel;

    // Use of the previous product inside a cell
    typedef enum logic [3:0] {
        A_NONE, A_ACC_CLR, A_ACC_ADD, A_ACC_ADDHI, A_SUM, A_TANH, A_CHAIN,
        A_X, A_WO, A_P, A_Q, A_D, A_B, A_W0, A_W1, A_W2
    } t_cell_act;

    typedef struct packed {
        t_mul_sel                  mul_sel;
        t_cell_act                 act;
        logic                      shift;
        logic                      load_en;
        logic [WIDX_W-1:0]         load_idx;
        logic signed [DATA_W-1:0]  load_val;
    } t_cell_cmd;

    typedef logic [15:0] t_tanh_rom [TANH_MAX_DEPTH];

    localparam int FWD_LAST = 7;
    localparam int LRN_LAST = 30;

    function automatic t_cell_cmd mk_cmd(input t_mul_sel m, input t_cell_act a);
        t_cell_cmd c;
        c          = '0;
        c.mul_sel  = m;
        c.act      = a;
        return c;
    endfunction

    // Forward pass program of every cell
    function automatic t_cell_cmd fwd_cmd(input logic [STEP_W-1:0] step);
        t_cell_cmd c;
        case (step)
            5'd0:    c = mk_cmd(M_X0,  A_NONE);
            5'd1:    c = mk_cmd(M_X1,  A_ACC_CLR);
            5'd2:    c = mk_cmd(M_X2,  A_ACC_ADD);
            5'd3:    c = mk_cmd(M_NONE, A_ACC_ADD);
            5'd4:    c = mk_cmd(M_NONE, A_SUM);
            5'd5:    c = mk_cmd(M_NONE, A_TANH);
            5'd6:    c = mk_cmd(M_HWO, A_NONE);
            5'd7:    c = mk_cmd(M_NONE, A_CHAIN);
            default: c = mk_cmd(M_NONE, A_NONE);
        endcase
        return c;
    endfunction

    // Learning program of every cell
    function automatic t_cell_cmd lrn_cmd(input logic [STEP_W-1:0] step);
        t_cell_cmd c;
        case (step)
            5'd0:    c = mk_cmd(M_GH,   A_NONE);
            5'd1:    c = mk_cmd(M_NONE, A_X);
            5'd2:    c = mk_cmd(M_LRLO, A_NONE);
            5'd3:    c = mk_cmd(M_LRHI, A_ACC_CLR);
            5'd4:    c = mk_cmd(M_NONE, A_ACC_ADDHI);
            5'd5:    c = mk_cmd(M_NONE, A_WO);
            5'd6:    c = mk_cmd(M_GWO,  A_NONE);
            5'd7:    c = mk_cmd(M_HH,   A_P);
            5'd8:    c = mk_cmd(M_NONE, A_Q);
            5'd9:    c = mk_cmd(M_PQ,   A_NONE);
            5'd10:   c = mk_cmd(M_NONE, A_D);
            5'd11:   c = mk_cmd(M_LRD,  A_NONE);
            5'd12:   c = mk_cmd(M_NONE, A_B);
            5'd13:   c = mk_cmd(M_DX0,  A_NONE);
            5'd19:   c = mk_cmd(M_DX1,  A_NONE);
            5'd25:   c = mk_cmd(M_DX2,  A_NONE);
            5'd14, 5'd20, 5'd26: c = mk_cmd(M_NONE, A_X);
            5'd15, 5'd21, 5'd27: c = mk_cmd(M_LRLO, A_NONE);
            5'd16, 5'd22, 5'd28: c = mk_cmd(M_LRHI, A_ACC_CLR);
            5'd17, 5'd23, 5'd29: c = mk_cmd(M_NONE, A_ACC_ADDHI);
            5'd18:   c = mk_cmd(M_NONE, A_W0);
            5'd24:   c = mk_cmd(M_NONE, A_W1);
            5'd30:   c = mk_cmd(M_NONE, A_W2);
            default: c = mk_cmd(M_NONE, A_NONE);
        endcase
        return c;
    endfunction

    // Saturate to the signed 24-bit range
    function automatic logic signed [DATA_W-1:0] sat24(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] r;
        if (v > S24_MAX) begin
            r = S24_MAX;
        end else if (v < S24_MIN) begin
            r = S24_MIN;
        end else begin
            r = v;
        end
        return r[DATA_W-1:0];
    endfunction

    // Clip to [-1,1] in Q16
    function automatic logic signed [NV_W-1:0] clip1(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] r;
        if (v > CLIP_HI) begin
            r = CLIP_HI;
        end else if (v < CLIP_LO) begin
            r = CLIP_LO;
        end else begin
            r = v;
        end
        return r[NV_W-1:0];
    endfunction

    // Angle scaling: trunc(raw*256/30), clamped to [-1,1]
    function automatic logic signed [NV_W-1:0] norm_angle(input logic signed [DATA_W-1:0] raw);
        logic [23:0] mag;
        logic [19:0] n;
        logic [40:0] p;
        logic [16:0] q;
        mag = raw[23] ? unsigned'(-raw) : unsigned'(raw);
        if (mag > ANG_LIMIT) begin
            q = 17'd65536;
        end else begin
            n = {mag[12:0], 7'b0};
            p = 41'(n) * 41'(ANG_RECIP);
            q = p[40:24];
        end
        return raw[23] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    // Rate scaling: trunc(raw*256/200), clamped to [-1,1]
    function automatic logic signed [NV_W-1:0] norm_rate(input logic signed [DATA_W-1:0] raw);
        logic [23:0] mag;
        logic [20:0] n;
        logic [42:0] p;
        logic [16:0] q;
        mag = raw[23] ? unsigned'(-raw) : unsigned'(raw);
        if (mag > RATE_LIMIT) begin
            q = 17'd65536;
        end else begin
            n = {mag[15:0], 5'b0};
            p = 43'(n) * 43'(RATE_RECIP);
            q = p[42:26];
        end
        return raw[23] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    // Shift-subtract quotient, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(4k/D) in Q0.16, built from a fixed-point exp series
    function automatic t_tanh_rom build_tanh(input int depth);
        t_tanh_rom   rom;
        logic [63:0] u;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] e;
        logic [63:0] stp;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] val;
        rom  = '{default: '0};
        u    = udiv64(64'd8 << 32, 64'(depth));
        term = 64'd1 << 32;
        sum  = 64'd1 << 32;
        e    = 64'd1 << 32;
        for (int n = 1; n <= 12; n++) begin
            term = udiv64((term * u) >> 32, 64'(n));
            if (n[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        stp = sum;
        for (int k = 0; k < depth; k++) begin
            num    = ((64'd1 << 32) - e) << 16;
            den    = (64'd1 << 32) + e;
            val    = udiv64(num + (den >> 1), den);
            rom[k] = val[15:0];
            e      = (e * stp) >> 32;
        end
        return rom;
    endfunction

endpackage

>>> sv/ngpc_cell.sv
// ============================================================================
// ngpc_cell : one hidden neuron of the gain network
// Holds its input weights, output weight, bias and activation, runs the
// broadcast micro-program on its own multiplier and passes its partial
// output product down the chain.
// ============================================================================
module ngpc_cell #(
    parameter int CELL_ID      = 0,
    parameter int HIDDEN_COUNT = ngpc_pkg::HIDDEN_COUNT_DEF,
    parameter int TANH_DEPTH   = ngpc_pkg::TANH_DEPTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  ngpc_pkg::t_cell_cmd                     i_cmd,
    input  logic signed [ngpc_pkg::NV_W-1:0]        i_x0,
    input  logic signed [ngpc_pkg::NV_W-1:0]        i_x1,
    input  logic signed [ngpc_pkg::NV_W-1:0]        i_x2,
    input  logic signed [ngpc_pkg::NV_W-1:0]        i_g,
    input  logic [ngpc_pkg::LR_W-1:0]               i_lr,
    input  logic signed [ngpc_pkg::CHAIN_W-1:0]     i_chain,
    output logic signed [ngpc_pkg::CHAIN_W-1:0]     o_chain
);
    import ngpc_pkg::*;

    localparam t_tanh_rom TANH_ROM = build_tanh(TANH_DEPTH);

    logic signed [DATA_W-1:0]  r_w0, r_w1, r_w2, r_wo, r_b, r_s;
    logic signed [NV_W-1:0]    r_h, r_p, r_q, r_d;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [X_W-1:0]     r_x;
    logic signed [CHAIN_W-1:0] r_chain;

    logic signed [OP_W-1:0]    mul_a, mul_b;
    logic signed [OP_W-1:0]    lr_op;
    logic [DATA_W:0]           abs_s;
    logic [47:0]               idx_full;
    logic [TANH_IDX_W-1:0]     tidx;
    logic [15:0]               tval;
    logic signed [NV_W-1:0]    n_h;
    int                        f;

    assign lr_op = $signed({9'b0, i_lr});
    assign f     = int'(i_cmd.load_idx);

    // Multiplier operand selection
    always_comb begin
        case (i_cmd.mul_sel)
            M_X0:    begin mul_a = OP_W'(i_x0);  mul_b = OP_W'(r_w0); end
            M_X1:    begin mul_a = OP_W'(i_x1);  mul_b = OP_W'(r_w1); end
            M_X2:    begin mul_a = OP_W'(i_x2);  mul_b = OP_W'(r_w2); end
            M_HWO:   begin mul_a = OP_W'(r_h);   mul_b = OP_W'(r_wo); end
            M_GH:    begin mul_a = OP_W'(i_g);   mul_b = OP_W'(r_h);  end
            M_LRLO:  begin mul_a = lr_op;        mul_b = $signed({7'b0, r_x[17:0]}); end
            M_LRHI:  begin mul_a = lr_op;        mul_b = OP_W'($signed(r_x[35:18])); end
            M_GWO:   begin mul_a = OP_W'(i_g);   mul_b = OP_W'(r_wo); end
            M_HH:    begin mul_a = OP_W'(r_h);   mul_b = OP_W'(r_h);  end
            M_PQ:    begin mul_a = OP_W'(r_p);   mul_b = OP_W'(r_q);  end
            M_LRD:   begin mul_a = lr_op;        mul_b = OP_W'(r_d);  end
            M_DX0:   begin mul_a = OP_W'(r_d);   mul_b = OP_W'(i_x0); end
            M_DX1:   begin mul_a = OP_W'(r_d);   mul_b = OP_W'(i_x1); end
            M_DX2:   begin mul_a = OP_W'(r_d);   mul_b = OP_W'(i_x2); end
            default: begin mul_a = '0;           mul_b = '0;          end
        endcase
    end

    // tanh lookup on the saturated neuron sum
    always_comb begin
        abs_s    = r_s[DATA_W-1] ? unsigned'(-(DATA_W+1)'(r_s)) : unsigned'((DATA_W+1)'(r_s));
        idx_full = 48'(abs_s) * 48'(TANH_DEPTH);
        if (idx_full[47:18] >= 30'(TANH_DEPTH)) begin
            tidx = TANH_IDX_W'(TANH_DEPTH - 1);
        end else begin
            tidx = idx_full[18+TANH_IDX_W-1:18];
        end
        tval = TANH_ROM[tidx];
        n_h  = r_s[DATA_W-1] ? -$signed({2'b0, tval}) : $signed({2'b0, tval});
    end

    // Product register
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Weight and state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w0 <= '0;
            r_w1 <= '0;
            r_w2 <= '0;
            r_wo <= '0;
            r_b  <= '0;
            r_h  <= '0;
        end else if (i_cmd.load_en) begin
            if (f == CELL_ID)                     r_w0 <= i_cmd.load_val;
            else if (f == HIDDEN_COUNT + CELL_ID)     r_w1 <= i_cmd.load_val;
            else if (f == 2 * HIDDEN_COUNT + CELL_ID) r_w2 <= i_cmd.load_val;
            else if (f == 3 * HIDDEN_COUNT + CELL_ID) r_wo <= i_cmd.load_val;
            else if (f == 4 * HIDDEN_COUNT + CELL_ID) r_b  <= i_cmd.load_val;
        end else begin
            case (i_cmd.act)
                A_TANH:  r_h  <= n_h;
                A_WO:    r_wo <= sat24(SAT_W'(r_wo) + SAT_W'(r_acc >>> 32));
                A_B:     r_b  <= sat24(SAT_W'(r_b) + SAT_W'(r_prod >>> 16));
                A_W0:    r_w0 <= sat24(SAT_W'(r_w0) + SAT_W'(r_acc >>> 32));
                A_W1:    r_w1 <= sat24(SAT_W'(r_w1) + SAT_W'(r_acc >>> 32));
                A_W2:    r_w2 <= sat24(SAT_W'(r_w2) + SAT_W'(r_acc >>> 32));
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.act)
            A_ACC_CLR:   r_acc <= ACC_W'(r_prod);
            A_ACC_ADD:   r_acc <= r_acc + ACC_W'(r_prod);
            A_ACC_ADDHI: r_acc <= r_acc + (ACC_W'(r_prod) <<< 18);
            A_SUM:       r_s   <= sat24(SAT_W'(r_acc >>> 16) + SAT_W'(r_b));
            A_X:         r_x   <= X_W'(r_prod);
            A_P:         r_p   <= clip1(SAT_W'(r_prod >>> 16));
            A_Q:         r_q   <= ONE_Q16 - NV_W'(r_prod >>> 16);
            A_D:         r_d   <= NV_W'(r_prod >>> 16);
            default:     ;
        endcase
    end

    // Output product chain
    always_ff @(posedge i_clk) begin
        if (i_cmd.act == A_CHAIN) begin
            r_chain <= CHAIN_W'(r_prod);
        end else if (i_cmd.shift) begin
            r_chain <= i_chain;
        end
    end

    assign o_chain = r_chain;

endmodule

>>> sv/neural_gain_p_controller_top.sv
// ============================================================================
// neural_gain_p_controller_top : attitude P controller with network gain
// Sequencer, input scaling, output reduction and drive computation around
// a chain of hidden-neuron cells.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one request: a control
//   tick, a control tick followed by a learn step, or a weight load.
//   Output channel (o_out_valid / i_out_ready) returns drive and gain, one
//   result per control tick; loads and unused kinds give none.
//   A weight load is written when it is accepted. A control tick runs, from
//   acceptance to result, scaling, 8 cell steps, HIDDEN_COUNT chain shifts,
//   gain and drive; a learn tick then adds the cell learning micro-program.
//   The cells work in lockstep on one multiplier each, so the chain length
//   sets the reduction time.
//   A new request is taken once the block is back in idle, even while a
//   result still waits in the output register; if the receiver stalls, the
//   next tick holds before its drive step until the register is free.
//   Reset clears all weights and biases to zero, the learning rate to 66
//   and the learning error to 1.0; configuration writes take effect at once.
// ============================================================================
module neural_gain_p_controller_top #(
    parameter int HIDDEN_COUNT     = ngpc_pkg::HIDDEN_COUNT_DEF,
    parameter int TANH_TABLE_DEPTH = ngpc_pkg::TANH_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [ngpc_pkg::KIND_W-1:0]           i_kind,
    input  logic signed [ngpc_pkg::DATA_W-1:0]    i_target_angle,
    input  logic signed [ngpc_pkg::DATA_W-1:0]    i_actual_angle,
    input  logic signed [ngpc_pkg::DATA_W-1:0]    i_actual_rate,
    input  logic [ngpc_pkg::WIDX_W-1:0]           i_weight_index,
    input  logic signed [ngpc_pkg::DATA_W-1:0]    i_weight_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [ngpc_pkg::DATA_W-1:0]    o_drive,
    output logic [ngpc_pkg::GAIN_W-1:0]           o_gain,
    input  logic                                  i_cfg_we,
    input  logic [ngpc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ngpc_pkg::DATA_W-1:0]           i_cfg_data
);
    import ngpc_pkg::*;

    t_state                    r_state, n_state;
    logic [STEP_W-1:0]         r_step, n_step;
    logic                      r_learn;
    logic                      r_out_valid;
    logic signed [DATA_W-1:0]  r_drive;
    logic [GAIN_W-1:0]         r_gain_out;
    logic signed [DATA_W-1:0]  r_ta, r_aa, r_ar;
    logic signed [NV_W-1:0]    r_x0, r_x1, r_x2;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [OSUM_W-1:0]  r_osum;
    logic signed [DATA_W-1:0]  r_ob;
    logic [GAIN_W-1:0]         r_gain;
    logic signed [47:0]        r_dp;
    logic [LR_W-1:0]           r_lr;
    logic signed [DATA_W-1:0]  r_le;

    t_cell_cmd                 cmd;
    logic                      accept;
    logic                      out_fire;
    logic signed [NV_W-1:0]    g;
    logic signed [DATA_W-1:0]  osat;
    logic signed [24:0]        adiff;
    logic signed [ERR_W-1:0]   err9;
    logic signed [35:0]        lrg;
    logic signed [CHAIN_W-1:0] w_chain [HIDDEN_COUNT];

    assign accept = i_in_valid && o_in_ready;
    assign g      = clip1(SAT_W'(r_le));
    assign lrg    = $signed({1'b0, r_lr}) * 36'(g);

    // Next state and cell commands
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_in_ready = 1'b0;
        out_fire   = 1'b0;
        cmd        = mk_cmd(M_NONE, A_NONE);
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_kind)
                        KIND_TICK, KIND_LEARN: n_state = ST_NORM;
                        KIND_LOAD: begin
                            cmd.load_en  = 1'b1;
                            cmd.load_idx = i_weight_index;
                            cmd.load_val = i_weight_value;
                        end
                        default: ;
                    endcase
                end
            end
            ST_NORM: begin
                n_state = ST_FWD;
                n_step  = '0;
            end
            ST_FWD: begin
                cmd = fwd_cmd(r_step);
                if (r_step == STEP_W'(FWD_LAST)) begin
                    n_state = ST_REDUCE;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_REDUCE: begin
                cmd.shift = 1'b1;
                if (r_step == STEP_W'(HIDDEN_COUNT - 1)) begin
                    n_state = ST_GAIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_GAIN:  n_state = ST_DMUL;
            ST_DMUL:  n_state = ST_DRIVE;
            ST_DRIVE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_fire = 1'b1;
                    n_state  = r_learn ? ST_LEARN : ST_IDLE;
                    n_step   = '0;
                end
            end
            ST_LEARN: begin
                cmd = lrn_cmd(r_step);
                if (r_step == STEP_W'(LRN_LAST)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Configuration registers and output bias
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr <= LEARN_RATE_RST;
            r_le <= LEARN_ERROR_RST;
            r_ob <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_LEARN_RATE:  r_lr <= i_cfg_data[LR_W-1:0];
                    REG_LEARN_ERROR: r_le <= $signed(i_cfg_data);
                    default: ;
                endcase
            end
            if (cmd.load_en && int'(i_weight_index) == 5 * HIDDEN_COUNT) begin
                r_ob <= i_weight_value;
            end else if (r_state == ST_LEARN && r_step == STEP_W'(3)) begin
                r_ob <= sat24(SAT_W'(r_ob) + SAT_W'(lrg >>> 16));
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            r_drive    <= sat24(SAT_W'(r_dp >>> 16));
            r_gain_out <= r_gain;
        end
    end

    // Angle error: floor(9*(T-A)/2) - R
    always_comb begin
        adiff = 25'(r_ta) - 25'(r_aa);
        err9  = (ERR_W'(adiff) <<< 3) + ERR_W'(adiff);
        osat  = sat24(SAT_W'(r_osum >>> 16) + SAT_W'(r_ob));
    end

    // Central datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ta    <= i_target_angle;
            r_aa    <= i_actual_angle;
            r_ar    <= i_actual_rate;
            r_learn <= (i_kind == KIND_LEARN);
        end
        if (r_state == ST_NORM) begin
            r_x0  <= norm_angle(r_ta);
            r_x1  <= norm_angle(r_aa);
            r_x2  <= norm_rate(r_ar);
            r_err <= (err9 >>> 1) - ERR_W'(r_ar);
        end
        if (r_state == ST_FWD) begin
            r_osum <= '0;
        end else if (r_state == ST_REDUCE) begin
            r_osum <= r_osum + OSUM_W'(w_chain[HIDDEN_COUNT-1]);
        end
        if (r_state == ST_GAIN) begin
            if (osat < GAIN_LO) begin
                r_gain <= GAIN_LO[GAIN_W-1:0];
            end else if (osat > GAIN_HI) begin
                r_gain <= GAIN_HI[GAIN_W-1:0];
            end else begin
                r_gain <= osat[GAIN_W-1:0];
            end
        end
        if (r_state == ST_DMUL) begin
            r_dp <= 48'($signed({1'b0, r_gain})) * 48'(r_err);
        end
    end

    // Chain of hidden-neuron cells
    for (genvar j = 0; j < HIDDEN_COUNT; j++) begin : g_cell
        logic signed [CHAIN_W-1:0] chain_in;
        if (j == 0) begin : g_head
            assign chain_in = '0;
        end else begin : g_link
            assign chain_in = w_chain[j-1];
        end
        ngpc_cell #(
            .CELL_ID      (j),
            .HIDDEN_COUNT (HIDDEN_COUNT),
            .TANH_DEPTH   (TANH_TABLE_DEPTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_x0    (r_x0),
            .i_x1    (r_x1),
            .i_x2    (r_x2),
            .i_g     (g),
            .i_lr    (r_lr),
            .i_chain (chain_in),
            .o_chain (w_chain[j])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;
    assign o_gain      = r_gain_out;

endmodule
